// ===== rtl/link_packet_unpacker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the link packet unpacker.
// Every macro assumes a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef LINK_PACKET_UNPACKER_MACROS_SVH
`define LINK_PACKET_UNPACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lpu_pkg.sv =====
// ----------------------------------------------------------------------------
// lpu_pkg
// Shared widths, constants and types of the link packet unpacker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpu_pkg;

  localparam int WORD_W       = 32;
  localparam int WORD_INDEX_W = 7;
  localparam int KIND_W       = 3;
  localparam int MAP_W        = 64;
  localparam int MAP_POS_W    = 6;
  localparam int CHANNEL_W    = 6;

  localparam int NUM_CHANNELS  = 36;
  localparam int HALF_CHANNELS = 18;

  // Map positions that carry channel samples.
  localparam logic [MAP_POS_W-1:0] CH_LO_FIRST = MAP_POS_W'(1);
  localparam logic [MAP_POS_W-1:0] CH_LO_LAST  = MAP_POS_W'(HALF_CHANNELS);
  localparam logic [MAP_POS_W-1:0] CH_HI_FIRST = MAP_POS_W'(HALF_CHANNELS + 3);
  localparam logic [MAP_POS_W-1:0] CH_HI_LAST  = MAP_POS_W'(NUM_CHANNELS + 2);
  localparam logic [MAP_POS_W-1:0] CH_LO_OFFS  = MAP_POS_W'(1);
  localparam logic [MAP_POS_W-1:0] CH_HI_OFFS  = MAP_POS_W'(3);

  localparam logic [WORD_W-1:0] IDLE_PATTERN   = 32'hACCC_CCCC;
  localparam logic [7:0]        BX_HEADER_MARK = 8'hAA;
  localparam int                IDLE_INDEX     = 41;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINK_HDR  = 3'd0,
    KIND_MAP_LO    = 3'd1,
    KIND_BUNCH_HDR = 3'd2,
    KIND_CHANNEL   = 3'd3,
    KIND_OTHER     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [WORD_INDEX_W-1:0] word_index;
    kind_t                   kind;
    logic [15:0]             link_id;
    logic                    crc_flag;
    logic [10:0]             bunch_id;
    logic [7:0]              write_addr;
    logic                    bunch_header_ok;
    logic [CHANNEL_W-1:0]    channel;
    logic [11:0]             time_over_thr;
    logic [9:0]              time_of_arrival;
    logic [9:0]              adc_value;
    logic                    idle_ok;
  } lpu_res_t;

endpackage

`default_nettype wire

// ===== rtl/lpu_stream_if.sv =====
// ----------------------------------------------------------------------------
// lpu stream interfaces
// Valid/ready channels for packet words in and labeled results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpu_in_if import lpu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink   (input valid, input word, input last_word, output ready);
endinterface

interface lpu_out_if import lpu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [WORD_INDEX_W-1:0] word_index;
  logic [KIND_W-1:0]       kind;
  logic [15:0]             link_id;
  logic                    crc_flag;
  logic [10:0]             bunch_id;
  logic [7:0]              write_addr;
  logic                    bunch_header_ok;
  logic [CHANNEL_W-1:0]    channel;
  logic [11:0]             time_over_thr;
  logic [9:0]              time_of_arrival;
  logic [9:0]              adc_value;
  logic                    idle_ok;

  modport source (
    output valid, output word_index, output kind, output link_id, output crc_flag,
    output bunch_id, output write_addr, output bunch_header_ok, output channel,
    output time_over_thr, output time_of_arrival, output adc_value, output idle_ok,
    input ready
  );
  modport sink (
    input valid, input word_index, input kind, input link_id, input crc_flag,
    input bunch_id, input write_addr, input bunch_header_ok, input channel,
    input time_over_thr, input time_of_arrival, input adc_value, input idle_ok,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/link_packet_unpacker.sv =====
// ----------------------------------------------------------------------------
// link_packet_unpacker
// Labels every 32-bit word of a zero-suppressed link packet as it streams in.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake       Payload
//   in_ch    in   valid / ready   word, last_word
//   out_ch   out  valid / ready   word_index, kind, header, bunch and sample fields
//
// One word is accepted per clock while in_ch.ready is high; its result passes
// an input register, then the decode into the result register, before it leaves.
// The set-bit search on the remaining map is the longest path of the decode.
// Synchronous active-low reset empties both stages and clears the word
// counter and the readout map. in_ch.ready drops only when both stages hold
// a word and out_ch.ready is low.
//
`timescale 1ns / 1ps
`default_nettype none

`include "link_packet_unpacker_macros.svh"

module link_packet_unpacker
  import lpu_pkg::*;
#(
  parameter int MAX_WORD_INDEX = 127
) (
  input  logic              clk,
  input  logic              rst_n,
  lpu_in_if.sink            in_ch,
  lpu_out_if.source         out_ch
);

  // The counter is at least as wide as the reported index so that the low
  // bits always give the index modulo 128.
  localparam int CW_RAW = $clog2(MAX_WORD_INDEX + 1);
  localparam int CW     = (CW_RAW > WORD_INDEX_W) ? CW_RAW : WORD_INDEX_W;
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_WORD_INDEX);
  localparam logic [CW-1:0] CNT_IDLE = CW'(IDLE_INDEX);

  // Input stage.
  logic              s1_v_r;
  logic [WORD_W-1:0] s1_word_r;
  logic              s1_last_r;

  // Result stage.
  logic     s2_v_r;
  lpu_res_t res_r;
  lpu_res_t res_nxt;

  // Packet state. rem_r holds the readout map bits that have not yet been
  // taken by a word: clearing the lowest set bit for each word is the same
  // as advancing a pointer to just past the next set bit.
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic [MAP_W-1:0] rem_r;
  logic [MAP_W-1:0] rem_nxt;

  logic                 adv2;
  logic                 step;
  logic [MAP_W-1:0]     rem_iso;
  logic [MAP_POS_W-1:0] pos;
  logic                 found;

  // The result stage frees up when it is empty or its word is taken; the
  // input stage then moves forward in the same cycle.
  assign adv2        = !s2_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || adv2;
  assign step        = s1_v_r && adv2;

  // Position of the next set map bit: isolate the lowest set bit, then
  // encode its one-hot position.
  always_comb begin
    rem_iso = rem_r & (~rem_r + MAP_W'(1));
    found   = |rem_r;
    pos     = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (rem_iso[i]) begin
        pos = pos | MAP_POS_W'(i);
      end
    end
  end

  // Decode of the word in the input stage.
  always_comb begin
    res_nxt            = '0;
    res_nxt.word_index = cnt_r[WORD_INDEX_W-1:0];
    res_nxt.kind       = KIND_OTHER;
    rem_nxt            = rem_r;

    if (cnt_r == '0) begin
      // Link header; it is also the upper half of the readout map.
      res_nxt.kind     = KIND_LINK_HDR;
      res_nxt.link_id  = s1_word_r[31:16];
      res_nxt.crc_flag = s1_word_r[15];
      rem_nxt          = {s1_word_r, 32'h0};
    end else if (cnt_r == CW'(1)) begin
      res_nxt.kind = KIND_MAP_LO;
      rem_nxt      = {rem_r[MAP_W-1:32], s1_word_r};
    end else begin
      // Every word from here on takes one set map bit, if one is left.
      rem_nxt = rem_r & (rem_r - MAP_W'(1));
      if (cnt_r == CW'(2)) begin
        // The bunch header always sits at word 2, whatever the map says.
        res_nxt.kind            = KIND_BUNCH_HDR;
        res_nxt.bunch_id        = s1_word_r[21:11];
        res_nxt.write_addr      = s1_word_r[10:3];
        res_nxt.bunch_header_ok = (s1_word_r[31:24] == BX_HEADER_MARK);
      end else if (found && pos >= CH_LO_FIRST && pos <= CH_LO_LAST) begin
        res_nxt.kind    = KIND_CHANNEL;
        res_nxt.channel = pos - CH_LO_OFFS;
      end else if (found && pos >= CH_HI_FIRST && pos <= CH_HI_LAST) begin
        res_nxt.kind    = KIND_CHANNEL;
        res_nxt.channel = pos - CH_HI_OFFS;
      end
      if (res_nxt.kind == KIND_CHANNEL) begin
        res_nxt.time_over_thr   = s1_word_r[31:20];
        res_nxt.time_of_arrival = s1_word_r[19:10];
        res_nxt.adc_value       = s1_word_r[9:0];
      end
    end

    res_nxt.idle_ok = (cnt_r == CNT_IDLE) && (s1_word_r == IDLE_PATTERN);

    // The last word of a packet returns counter and map to their start.
    if (s1_last_r) begin
      cnt_nxt = '0;
      rem_nxt = '0;
    end else if (cnt_r < CNT_MAX) begin
      cnt_nxt = cnt_r + CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (adv2) begin
        s2_v_r <= s1_v_r;
      end
      if (step) begin
        cnt_r <= cnt_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_word_r <= in_ch.word;
      s1_last_r <= in_ch.last_word;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = s2_v_r;
  assign out_ch.word_index      = res_r.word_index;
  assign out_ch.kind            = res_r.kind;
  assign out_ch.link_id         = res_r.link_id;
  assign out_ch.crc_flag        = res_r.crc_flag;
  assign out_ch.bunch_id        = res_r.bunch_id;
  assign out_ch.write_addr      = res_r.write_addr;
  assign out_ch.bunch_header_ok = res_r.bunch_header_ok;
  assign out_ch.channel         = res_r.channel;
  assign out_ch.time_over_thr   = res_r.time_over_thr;
  assign out_ch.time_of_arrival = res_r.time_of_arrival;
  assign out_ch.adc_value       = res_r.adc_value;
  assign out_ch.idle_ok         = res_r.idle_ok;

  `LPU_ASSERT_SAME(a_channel_range, s2_v_r && res_r.kind == KIND_CHANNEL,
    res_r.channel < CHANNEL_W'(NUM_CHANNELS), "channel number out of range")
  `LPU_ASSERT_SAME(a_link_hdr_first, s2_v_r && res_r.kind == KIND_LINK_HDR,
    res_r.word_index == '0, "link header reported away from word 0")
  `LPU_ASSERT_NEXT(a_last_restarts, step && s1_last_r,
    cnt_r == '0 && rem_r == '0, "packet state not cleared after last word")
  `LPU_ASSERT_NEXT(a_map_only_shrinks,
    step && !s1_last_r && cnt_r != '0 && cnt_r != CW'(1),
    (rem_r & ~$past(rem_r)) == '0, "readout map gained bits after word 1")

endmodule

`default_nettype wire

// ===== test/link_packet_unpacker_tb.sv =====
// ----------------------------------------------------------------------------
// link_packet_unpacker_tb
// Streams zero-suppressed link packets into the unpacker and checks the label
// of every word against an in-bench model of the packet decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_packet_unpacker_tb
  import lpu_pkg::*;
();

  localparam int MAX_WORD_INDEX = 127;
  localparam int IDLE_PCT       = 14;       // chance in a hundred that a side idles
  localparam int HOLD_AT        = 400;      // words in before the long output stall
  localparam int HOLD_CYCLES    = 80;
  localparam int CALM_FIRST     = 900;      // window of words with no idling at all
  localparam int CALM_LAST      = 1200;
  localparam int HALF_WORDS     = 950;
  localparam int TOTAL_WORDS    = 1900;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 200_000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              last;
  } link_word_t;

  logic clk = 1'b0;
  logic rst_n;

  lpu_in_if  in_if ();
  lpu_out_if out_if ();

  link_packet_unpacker #(
    .MAX_WORD_INDEX(MAX_WORD_INDEX)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if.sink),
    .out_ch(out_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be offered, and labels predicted for words already taken.
  link_word_t words_to_send[$];
  lpu_res_t   pending_labels[$];

  int unsigned words_queued = 0;
  int unsigned words_in = 0;
  int unsigned labels_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        in_fire = 1'b0;

  // Output stall bookkeeping, owned by the ready driver.
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // Both sides stop idling while the word count is inside the calm window.
  wire calm = (words_in >= CALM_FIRST) && (words_in < CALM_LAST);

  // --------------------------------------------------------------------------
  // Packet decode model. It keeps its own copy of the word position, the
  // 64-bit readout map and the cursor of the set-bit search.
  // --------------------------------------------------------------------------
  logic [WORD_INDEX_W-1:0] pkt_pos = '0;
  logic [MAP_W-1:0]        pkt_map = '0;
  logic [6:0]              map_cursor = '0;

  function automatic lpu_res_t label_word(logic [WORD_W-1:0] w, logic last);
    lpu_res_t    r;
    int unsigned hit;
    int          i;
    r            = '0;
    r.kind       = KIND_OTHER;
    r.word_index = pkt_pos;
    if (pkt_pos == 0) begin
      // The link header doubles as the upper half of the readout map.
      r.kind     = KIND_LINK_HDR;
      r.link_id  = w[31:16];
      r.crc_flag = w[15];
      pkt_map    = {w, 32'h0};
    end else if (pkt_pos == 1) begin
      r.kind        = KIND_MAP_LO;
      pkt_map[31:0] = w;
    end else begin
      // Every word from the bunch header on takes the next set map bit,
      // or none once the map is used up.
      hit = MAP_W;
      for (i = MAP_W - 1; i >= 0; i--) begin
        if (i >= map_cursor && pkt_map[i]) hit = i;
      end
      map_cursor = (hit < MAP_W) ? 7'(hit + 1) : 7'(MAP_W);
      if (pkt_pos == 2) begin
        r.kind            = KIND_BUNCH_HDR;
        r.bunch_id        = w[21:11];
        r.write_addr      = w[10:3];
        r.bunch_header_ok = (w[31:24] == BX_HEADER_MARK);
      end else if (hit >= 1 && hit <= HALF_CHANNELS) begin
        r.kind    = KIND_CHANNEL;
        r.channel = CHANNEL_W'(hit - 1);
      end else if (hit >= HALF_CHANNELS + 3 && hit <= NUM_CHANNELS + 2) begin
        r.kind    = KIND_CHANNEL;
        r.channel = CHANNEL_W'(hit - 3);
      end
      if (r.kind == KIND_CHANNEL) begin
        r.time_over_thr   = w[31:20];
        r.time_of_arrival = w[19:10];
        r.adc_value       = w[9:0];
      end
    end
    r.idle_ok = (pkt_pos == IDLE_INDEX) && (w == IDLE_PATTERN);
    if (last) begin
      pkt_pos    = '0;
      pkt_map    = '0;
      map_cursor = '0;
    end else if (pkt_pos < MAX_WORD_INDEX) begin
      pkt_pos = pkt_pos + 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("label %0d: %s expected 0x%0h, got 0x%0h", labels_seen, name, want, got);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offers the next queued word at the falling edge, holds it
  // until the rising edge takes it, and idles at random outside the calm
  // window.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    link_word_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (words_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = words_to_send.pop_front();
        in_if.valid     <= 1'b1;
        in_if.word      <= nxt.data;
        in_if.last_word <= nxt.last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output ready driver. Once enough words have gone in, it stalls the output
  // for a long stretch so that both stages fill and the input side backs up.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (!hold_done && words_in >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge, a word taken on the input gets its label
  // predicted, and a result taken on the output is checked against the
  // oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lpu_res_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        pending_labels.push_back(label_word(in_if.word, in_if.last_word));
        words_in <= words_in + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_labels.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("label %0d arrived with no word outstanding", labels_seen);
          end
        end else begin
          want = pending_labels.pop_front();
          check_field("word_index", 32'(want.word_index), 32'(out_if.word_index));
          check_field("kind", 32'(want.kind), 32'(out_if.kind));
          check_field("link_id", 32'(want.link_id), 32'(out_if.link_id));
          check_field("crc_flag", 32'(want.crc_flag), 32'(out_if.crc_flag));
          check_field("bunch_id", 32'(want.bunch_id), 32'(out_if.bunch_id));
          check_field("write_addr", 32'(want.write_addr), 32'(out_if.write_addr));
          check_field("bunch_header_ok", 32'(want.bunch_header_ok),
                      32'(out_if.bunch_header_ok));
          check_field("channel", 32'(want.channel), 32'(out_if.channel));
          check_field("time_over_thr", 32'(want.time_over_thr),
                      32'(out_if.time_over_thr));
          check_field("time_of_arrival", 32'(want.time_of_arrival),
                      32'(out_if.time_of_arrival));
          check_field("adc_value", 32'(want.adc_value), 32'(out_if.adc_value));
          check_field("idle_ok", 32'(want.idle_ok), 32'(out_if.idle_ok));
        end
        labels_seen <= labels_seen + 1;
      end
    end
  end

  // A run that has not finished within the cycle limit ends here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_word(logic [WORD_W-1:0] data, logic last);
    words_to_send.push_back('{data: data, last: last});
    words_queued++;
  endtask

  // One packet: link header, map low word, bunch header, then payload words.
  // Payload words are random, with the idle pattern now and then at any
  // position and on demand at the idle check position.
  task automatic queue_packet(int unsigned len, logic [WORD_W-1:0] hdr,
                              logic [WORD_W-1:0] map_lo, bit bx_good, bit idle_word);
    int unsigned k;
    logic [7:0]  top;
    logic [WORD_W-1:0] w;
    for (k = 0; k < len; k++) begin
      if (k == 0) begin
        w = hdr;
      end else if (k == 1) begin
        w = map_lo;
      end else if (k == 2) begin
        top = 8'($urandom_range(254));
        if (top >= BX_HEADER_MARK) top = top + 1'b1;
        w = {bx_good ? BX_HEADER_MARK : top, 24'($urandom)};
      end else if (k == IDLE_INDEX) begin
        w = idle_word ? IDLE_PATTERN : (IDLE_PATTERN ^ (32'h1 << $urandom_range(31)));
      end else if ($urandom_range(19) == 0) begin
        w = IDLE_PATTERN;
      end else begin
        w = $urandom;
      end
      queue_word(w, k == len - 1);
    end
  endtask

  // A random packet: mostly well-formed lengths with random maps, some runt
  // packets, some that reach the idle check, and a few long enough to
  // saturate the word position.
  task automatic queue_random_packet();
    int unsigned roll;
    int unsigned len;
    logic [WORD_W-1:0] hdr;
    logic [WORD_W-1:0] lo;
    roll = $urandom_range(99);
    if (roll < 10)      len = $urandom_range(3, 1);
    else if (roll < 80) len = $urandom_range(41, 4);
    else if (roll < 97) len = $urandom_range(60, 42);
    else                len = $urandom_range(140, 128);
    case ($urandom_range(3))
      0: begin
        hdr = $urandom;
        lo  = $urandom;
      end
      1: begin
        hdr = $urandom & $urandom & $urandom;
        lo  = $urandom & $urandom & $urandom;
      end
      2: begin
        hdr = $urandom | $urandom;
        lo  = $urandom | $urandom;
      end
      default: begin
        hdr = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        lo  = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      end
    endcase
    queue_packet(len, hdr, lo, $urandom_range(3) != 0, $urandom_range(9) < 7);
  endtask

  // Holds the sender until every word has gone in and every label came out.
  task automatic wait_drained();
    while (words_to_send.size() != 0 || in_if.valid || pending_labels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.word      = '0;
    in_if.last_word = 1'b0;
    out_if.ready    = 1'b0;

    // Single-word packet of all ones: maximum link id, CRC flag set.
    queue_word(32'hFFFF_FFFF, 1'b1);
    // Two-word packet of zeros ends right after the map.
    queue_word(32'h0, 1'b0);
    queue_word(32'h0, 1'b1);
    // Empty map: the bunch header still shows up, then the map is exhausted.
    // The header carries a good mark and all-ones bunch id and address.
    queue_word(32'h0, 1'b0);
    queue_word(32'h0, 1'b0);
    queue_word(32'hAA3F_FFF8, 1'b0);
    queue_word(32'h1234_5678, 1'b1);
    // Map bits 0, 1, 18, 19, 20, 21, 38, 39 and 63: the bunch header eats
    // bit 0, then the first and last channel of each half, the gap
    // positions, the positions past the channels, and the exhausted map.
    queue_word(32'h8000_00C0, 1'b0);
    queue_word(32'h003C_0003, 1'b0);
    queue_word(32'h5500_0000, 1'b0);
    queue_word(32'hFFFF_FFFF, 1'b0);
    queue_word(32'h0000_0000, 1'b0);
    queue_word(32'hFFFF_FFFF, 1'b0);
    queue_word($urandom, 1'b0);
    queue_word(32'hFFF0_0000, 1'b0);
    queue_word(32'h000F_FFFF, 1'b0);
    queue_word(IDLE_PATTERN, 1'b0);
    queue_word($urandom, 1'b0);
    queue_word($urandom, 1'b1);

    // Make sure the idle check and word position saturation are reached early.
    queue_packet(45, $urandom, $urandom, 1'b1, 1'b1);
    queue_packet(135, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_queued < HALF_WORDS) queue_random_packet();
    // The sender pauses here until the unpacker has emptied out.
    wait_drained();
    while (words_queued < TOTAL_WORDS) queue_random_packet();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_labels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lpu_pkg.sv
rtl/lpu_stream_if.sv
rtl/link_packet_unpacker.sv
test/link_packet_unpacker_tb.sv
